/* hw/rtl/lspp_pkg.sv */
package lspp_pkg;

  localparam int CORDIC_STAGES = 16;
  localparam int RANGE_BITS    = 16;

  localparam int XW    = 36;
  localparam int ZW    = 32;
  localparam int STG_W = (CORDIC_STAGES > 1) ? $clog2(CORDIC_STAGES) : 1;
  localparam int PW    = XW - 15;
  localparam int OW    = 25;
  localparam int OFS_W = 24;

  localparam logic [15:0] RANGE_LIM  = (RANGE_BITS >= 16) ? 16'hFFFF
                                     : 16'((1 << RANGE_BITS) - 1);
  localparam logic [31:0] CORDIC_K   = 32'h9B74EDA8;

  localparam logic [2:0] CFG_START_ANGLE = 3'd0;
  localparam logic [2:0] CFG_ANGLE_STEP  = 3'd1;
  localparam logic [2:0] CFG_RANGE_LO    = 3'd2;
  localparam logic [2:0] CFG_RANGE_HI    = 3'd3;
  localparam logic [2:0] CFG_OFFSET_X    = 3'd4;
  localparam logic [2:0] CFG_OFFSET_Y    = 3'd5;

  typedef struct packed {
    logic signed [XW-1:0] x;
    logic signed [XW-1:0] y;
    logic signed [ZW-1:0] z;
    logic [1:0]           q;
    logic                 kept;
    logic                 last;
  } cdc_t;

  function automatic logic signed [ZW-1:0] atan_f(input logic [4:0] i);
    logic signed [ZW-1:0] v;
    case (i)
      5'd0:    v = 32'h20000000;
      5'd1:    v = 32'h12E4051D;
      5'd2:    v = 32'h09FB385B;
      5'd3:    v = 32'h051111D4;
      5'd4:    v = 32'h028B0D43;
      5'd5:    v = 32'h0145D7E1;
      5'd6:    v = 32'h00A2F61E;
      5'd7:    v = 32'h00517C55;
      5'd8:    v = 32'h0028BE53;
      5'd9:    v = 32'h00145F2E;
      5'd10:   v = 32'h000A2F98;
      5'd11:   v = 32'h000517CC;
      5'd12:   v = 32'h00028BE6;
      5'd13:   v = 32'h000145F3;
      5'd14:   v = 32'h0000A2F9;
      5'd15:   v = 32'h0000517C;
      5'd16:   v = 32'h000028BE;
      5'd17:   v = 32'h0000145F;
      5'd18:   v = 32'h00000A2F;
      5'd19:   v = 32'h00000517;
      5'd20:   v = 32'h0000028B;
      5'd21:   v = 32'h00000145;
      5'd22:   v = 32'h000000A2;
      5'd23:   v = 32'h00000051;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

/* hw/rtl/lspp_cordic_cell.sv */
module lspp_cordic_cell (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic [lspp_pkg::STG_W-1:0] stage_idx,
  input  logic                     in_vld,
  input  lspp_pkg::cdc_t           in_data,
  input  logic                     stall_dn,
  output logic                     out_vld,
  output lspp_pkg::cdc_t           out_data,
  output logic                     stall_up
);

  logic           vld_r;
  lspp_pkg::cdc_t data_r;
  lspp_pkg::cdc_t data_nxt;
  logic signed [lspp_pkg::XW-1:0] xs;
  logic signed [lspp_pkg::XW-1:0] ys;
  logic signed [lspp_pkg::ZW-1:0] at;

  assign stall_up = vld_r & stall_dn;

  always_comb begin
    xs       = in_data.x >>> stage_idx;
    ys       = in_data.y >>> stage_idx;
    at       = lspp_pkg::atan_f(5'(stage_idx));
    data_nxt = in_data;
    if (!in_data.z[lspp_pkg::ZW-1]) begin
      data_nxt.x = in_data.x - ys;
      data_nxt.y = in_data.y + xs;
      data_nxt.z = in_data.z - at;
    end else begin
      data_nxt.x = in_data.x + ys;
      data_nxt.y = in_data.y - xs;
      data_nxt.z = in_data.z + at;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (!stall_up) begin
      vld_r <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (!stall_up) begin
      data_r <= data_nxt;
    end
  end

  assign out_vld  = vld_r;
  assign out_data = data_r;

endmodule

/* hw/rtl/lspp_finish.sv */
module lspp_finish (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_vld,
  input  lspp_pkg::cdc_t                      in_data,
  output logic                                stall_up,
  input  logic signed [lspp_pkg::OFS_W-1:0]   offset_x,
  input  logic signed [lspp_pkg::OFS_W-1:0]   offset_y,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [lspp_pkg::OW-1:0]      out_point_x,
  output logic signed [lspp_pkg::OW-1:0]      out_point_y,
  output logic                                out_point_kept,
  output logic                                out_scan_end_out
);

  localparam logic signed [lspp_pkg::XW-1:0] RND = lspp_pkg::XW'(32768);
  localparam logic signed [lspp_pkg::OW:0]   OMAX = (lspp_pkg::OW+1)'(16777215);
  localparam logic signed [lspp_pkg::OW:0]   OMIN = -(lspp_pkg::OW+1)'(16777216);

  logic signed [lspp_pkg::XW-1:0] sx, sy;
  logic signed [lspp_pkg::PW-2:0] rx, ry;
  logic signed [lspp_pkg::PW-1:0] px_nxt, py_nxt;
  logic signed [lspp_pkg::PW-1:0] px_r, py_r;
  logic                           kept_r, last_r, mid_vld_r;
  logic                           mid_stall, out_hold;

  logic signed [lspp_pkg::OW:0] ax, ay;
  logic signed [lspp_pkg::OW-1:0] qx_nxt, qy_nxt;
  logic signed [lspp_pkg::OW-1:0] qx_r, qy_r;
  logic                           okept_r, olast_r, ovld_r;

  assign out_hold  = ovld_r & out_stall;
  assign mid_stall = mid_vld_r & out_hold;
  assign stall_up  = mid_stall;

  always_comb begin
    sx = in_data.x + RND;
    sy = in_data.y + RND;
    rx = sx[lspp_pkg::XW-1:16];
    ry = sy[lspp_pkg::XW-1:16];
    case (in_data.q)
      2'd0: begin
        px_nxt = lspp_pkg::PW'(rx);
        py_nxt = lspp_pkg::PW'(ry);
      end
      2'd1: begin
        px_nxt = -lspp_pkg::PW'(ry);
        py_nxt = lspp_pkg::PW'(rx);
      end
      2'd2: begin
        px_nxt = -lspp_pkg::PW'(rx);
        py_nxt = -lspp_pkg::PW'(ry);
      end
      default: begin
        px_nxt = lspp_pkg::PW'(ry);
        py_nxt = -lspp_pkg::PW'(rx);
      end
    endcase
  end

  always_comb begin
    ax = (lspp_pkg::OW+1)'(px_r) + (lspp_pkg::OW+1)'(offset_x);
    ay = (lspp_pkg::OW+1)'(py_r) + (lspp_pkg::OW+1)'(offset_y);
    if (!kept_r) begin
      qx_nxt = '0;
    end else if (ax > OMAX) begin
      qx_nxt = OMAX[lspp_pkg::OW-1:0];
    end else if (ax < OMIN) begin
      qx_nxt = OMIN[lspp_pkg::OW-1:0];
    end else begin
      qx_nxt = ax[lspp_pkg::OW-1:0];
    end
    if (!kept_r) begin
      qy_nxt = '0;
    end else if (ay > OMAX) begin
      qy_nxt = OMAX[lspp_pkg::OW-1:0];
    end else if (ay < OMIN) begin
      qy_nxt = OMIN[lspp_pkg::OW-1:0];
    end else begin
      qy_nxt = ay[lspp_pkg::OW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mid_vld_r <= 1'b0;
      ovld_r    <= 1'b0;
    end else begin
      if (!mid_stall) begin
        mid_vld_r <= in_vld;
      end
      if (!out_hold) begin
        ovld_r <= mid_vld_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!mid_stall) begin
      px_r   <= px_nxt;
      py_r   <= py_nxt;
      kept_r <= in_data.kept;
      last_r <= in_data.last;
    end
    if (!out_hold) begin
      qx_r    <= qx_nxt;
      qy_r    <= qy_nxt;
      okept_r <= kept_r;
      olast_r <= last_r;
    end
  end

  assign out_valid        = ovld_r;
  assign out_point_x      = qx_r;
  assign out_point_y      = qy_r;
  assign out_point_kept   = okept_r;
  assign out_scan_end_out = olast_r;

endmodule

/* hw/rtl/lidar_scan_point_projector.sv */
// Lidar scan point projector.
// Input channel (in_valid/in_stall): one range sample per transaction with
// its finite flag and end-of-scan mark. Output channel (out_valid/out_stall):
// exactly one projected point per input transaction, in order.
// Configuration: cfg_we writes cfg_wdata to register cfg_idx;
// write only while the block is idle. Unknown indexes are ignored.
// Pipeline: CORDIC_STAGES + 4 register stages (20 at 16 stages), in order:
// entry stage, gain multiply, one register per rotation cell,
// rounding/quarter-turn stage, offset/saturate output register.
// Throughput: one transaction per cycle; unstalled, every stage advances.
// When out_stall holds, occupied stages hold their data and empty stages
// keep filling, so in_stall rises only once the pipeline is full.
// Reset (rst_n low, synchronous) empties the pipeline, clears the beam
// angle accumulator and loads the register defaults (upper range limit
// 65535, all others 0).
module lidar_scan_point_projector (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [15:0]                        in_range_mm,
  input  logic                               in_range_finite,
  input  logic                               in_scan_end,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic signed [lspp_pkg::OW-1:0]     out_point_x,
  output logic signed [lspp_pkg::OW-1:0]     out_point_y,
  output logic                               out_point_kept,
  output logic                               out_scan_end_out,
  input  logic                               cfg_we,
  input  logic [2:0]                         cfg_idx,
  input  logic [lspp_pkg::OFS_W-1:0]         cfg_wdata
);

  localparam int N = lspp_pkg::CORDIC_STAGES;

  logic [15:0]                      start_angle_r, angle_step_r;
  logic [15:0]                      range_lo_r, range_hi_r;
  logic signed [lspp_pkg::OFS_W-1:0] offset_x_r, offset_y_r;
  logic [15:0]                      accum_r, accum_nxt;

  logic        in_acc;
  logic [15:0] r_sat;
  logic        kept_nxt;

  logic        e_vld_r, e_stall;
  logic [15:0] e_range_r, e_angle_r;
  logic        e_kept_r, e_last_r;

  logic           p_vld_r, p_stall;
  lspp_pkg::cdc_t p_data_r, p_data_nxt;
  logic [47:0]    prod;
  logic [15:0]    a_bias, a_res;
  logic [1:0]     q;

  logic           c_vld   [N+1];
  lspp_pkg::cdc_t c_data  [N+1];
  logic           c_stall [N+1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_angle_r <= '0;
      angle_step_r  <= '0;
      range_lo_r    <= '0;
      range_hi_r    <= 16'hFFFF;
      offset_x_r    <= '0;
      offset_y_r    <= '0;
    end else if (cfg_we) begin
      case (cfg_idx)
        lspp_pkg::CFG_START_ANGLE: start_angle_r <= cfg_wdata[15:0];
        lspp_pkg::CFG_ANGLE_STEP:  angle_step_r  <= cfg_wdata[15:0];
        lspp_pkg::CFG_RANGE_LO:    range_lo_r    <= cfg_wdata[15:0];
        lspp_pkg::CFG_RANGE_HI:    range_hi_r    <= cfg_wdata[15:0];
        lspp_pkg::CFG_OFFSET_X:    offset_x_r    <= cfg_wdata;
        lspp_pkg::CFG_OFFSET_Y:    offset_y_r    <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign e_stall  = e_vld_r & p_stall;
  assign in_stall = e_stall;
  assign in_acc   = in_valid & ~e_stall;

  always_comb begin
    r_sat     = (in_range_mm > lspp_pkg::RANGE_LIM) ? lspp_pkg::RANGE_LIM : in_range_mm;
    kept_nxt  = in_range_finite & (r_sat >= range_lo_r) & (r_sat <= range_hi_r);
    accum_nxt = in_scan_end ? 16'd0 : accum_r + angle_step_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      accum_r <= '0;
      e_vld_r <= 1'b0;
    end else begin
      if (in_acc) begin
        accum_r <= accum_nxt;
      end
      if (!e_stall) begin
        e_vld_r <= in_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!e_stall) begin
      e_range_r <= r_sat;
      e_angle_r <= start_angle_r + accum_r;
      e_kept_r  <= kept_nxt;
      e_last_r  <= in_scan_end;
    end
  end

  // gain prescale and quarter-turn split
  assign p_stall = p_vld_r & c_stall[0];

  always_comb begin
    prod   = 48'(e_range_r) * 48'(lspp_pkg::CORDIC_K);
    a_bias = e_angle_r + 16'h2000;
    q      = a_bias[15:14];
    a_res  = e_angle_r - {q, 14'd0};
    p_data_nxt.x    = {{(lspp_pkg::XW-32){1'b0}}, prod[47:16]};
    p_data_nxt.y    = '0;
    p_data_nxt.z    = {a_res, 16'd0};
    p_data_nxt.q    = q;
    p_data_nxt.kept = e_kept_r;
    p_data_nxt.last = e_last_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p_vld_r <= 1'b0;
    end else if (!p_stall) begin
      p_vld_r <= e_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!p_stall) begin
      p_data_r <= p_data_nxt;
    end
  end

  assign c_vld[0]  = p_vld_r;
  assign c_data[0] = p_data_r;

  for (genvar k = 0; k < N; k++) begin : g_cell
    lspp_cordic_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .stage_idx (lspp_pkg::STG_W'(k)),
      .in_vld    (c_vld[k]),
      .in_data   (c_data[k]),
      .stall_dn  (c_stall[k+1]),
      .out_vld   (c_vld[k+1]),
      .out_data  (c_data[k+1]),
      .stall_up  (c_stall[k])
    );
  end

  lspp_finish u_finish (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_vld           (c_vld[N]),
    .in_data          (c_data[N]),
    .stall_up         (c_stall[N]),
    .offset_x         (offset_x_r),
    .offset_y         (offset_y_r),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_point_x      (out_point_x),
    .out_point_y      (out_point_y),
    .out_point_kept   (out_point_kept),
    .out_scan_end_out (out_scan_end_out)
  );

endmodule
